// File: hdl/drpi_pkg.sv
// shared types, constants and functions of the dead-reckoning pose integrator
package drpi_pkg;

  localparam int FracBits    = 16;
  localparam int MaxSubsteps = 64;
  localparam int CordicIters = 28;
  localparam int IterW       = 5;
  localparam int CountW      = 7;
  localparam int DivW        = 56;
  localparam int ProdW       = 56;

  localparam logic [31:0] BamPerRad = 32'd683565276;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] linear_speed;
    logic signed [31:0] turn_rate;
    logic [23:0]        elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] cos_val;
    logic signed [33:0] sin_val;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_bam(input logic [IterW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
        5'd20: r = 32'd652;        5'd21: r = 32'd326;
        5'd22: r = 32'd163;        5'd23: r = 32'd81;
        5'd24: r = 32'd41;         5'd25: r = 32'd20;
        5'd26: r = 32'd10;         5'd27: r = 32'd5;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: hdl/drpi_cordic.sv
// iterative rotation-mode cordic giving cosine and sine of a binary angle in q30
module drpi_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  drpi_pkg::cordic_req_t req,
  output drpi_pkg::cordic_rsp_t rsp
);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic [drpi_pkg::IterW-1:0] iter;
  logic busy;
  logic done;
  logic [31:0] ang_adj;
  logic left_half;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] atan_s;

  assign left_half = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
  assign ang_adj   = left_half ? (req.angle + 32'h8000_0000) : req.angle;
  assign xs        = x >>> iter;
  assign ys        = y >>> iter;
  assign atan_s    = $signed({1'b0, drpi_pkg::atan_bam(iter)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        iter <= '0;
        x    <= left_half ? -drpi_pkg::CordicGain : drpi_pkg::CordicGain;
        y    <= '0;
        z    <= $signed({ang_adj[31], ang_adj});
      end else if (busy) begin
        if (!z[32]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_s;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_s;
        end
        if (iter == drpi_pkg::IterW'(drpi_pkg::CordicIters - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          iter <= iter + 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.cos_val = x;
  assign rsp.sin_val = y;

endmodule

// File: hdl/dead_reckoning_pose_integrator.sv
// top level: fixed-point unicycle odometry with euler substeps
// sequence: speed and turn rate are each multiplied by the elapsed time, then divided by n
// in one shared divider (n the clamped substep count); the turn step becomes a binary angle,
// and each substep runs cordic and mac. one request at a time: in_stall stays high until the
// pose is loaded in the output register, and a waiting result holds back that load
// synchronous active-high reset clears the pose to zero and substep count to one
module dead_reckoning_pose_integrator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  drpi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output drpi_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MULV  = 11'b000_0000_0010,
    S_DIVV  = 11'b000_0000_0100,
    S_MULW  = 11'b000_0000_1000,
    S_DIVW  = 11'b000_0001_0000,
    S_BAM   = 11'b000_0010_0000,
    S_ROT   = 11'b000_0100_0000,
    S_WAIT  = 11'b000_1000_0000,
    S_MULX  = 11'b001_0000_0000,
    S_MULY  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic [drpi_pkg::CountW-1:0] substep_count;
  logic [drpi_pkg::CountW-1:0] n_eff;
  logic [drpi_pkg::CountW-1:0] remaining;
  logic [31:0] x_position;
  logic [31:0] y_position;
  logic [31:0] heading_angle;
  logic [23:0] t_reg;
  logic [32:0] vmag;
  logic [32:0] wmag;
  logic vneg;
  logic wneg;
  logic signed [32:0] step_dist;
  logic [31:0] bam;
  logic [drpi_pkg::ProdW-1:0] rem;
  logic [drpi_pkg::ProdW-1:0] quo;
  logic [5:0] div_cnt;
  logic [drpi_pkg::DivW-1:0] divisor;
  logic [drpi_pkg::DivW:0] trial;
  logic [drpi_pkg::ProdW-1:0] q_sat;
  logic [63:0] bam_lo;
  logic [drpi_pkg::FracBits-1:0] bam_hi;
  logic [31:0] bam_raw;
  logic signed [66:0] mac;
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;
  logic out_load;
  drpi_pkg::cordic_req_t creq;
  drpi_pkg::cordic_rsp_t crsp;

  drpi_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  assign n_eff = (substep_count == '0) ? drpi_pkg::CountW'(1) :
                 (substep_count > drpi_pkg::CountW'(drpi_pkg::MaxSubsteps)) ?
                 drpi_pkg::CountW'(drpi_pkg::MaxSubsteps) : substep_count;
  assign divisor = drpi_pkg::DivW'(n_eff) << drpi_pkg::FracBits;
  assign trial = {1'b0, rem[drpi_pkg::ProdW-2:0], quo[drpi_pkg::ProdW-1]}
                 - {1'b0, divisor};
  assign creq.start = (state == S_ROT);
  assign creq.angle = heading_angle;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (remaining == '0) && (!out_valid || !out_stall);

  // low 32 quotient bits times the scale, upper bits only reach the kept window
  assign bam_lo  = {32'd0, quo[31:0]} * {32'd0, drpi_pkg::BamPerRad}
                   + (64'd1 << (drpi_pkg::FracBits - 1));
  assign bam_hi  = drpi_pkg::FracBits'(quo[32 +: drpi_pkg::FracBits]
                   * drpi_pkg::BamPerRad[drpi_pkg::FracBits-1:0]);
  assign bam_raw = bam_lo[drpi_pkg::FracBits +: 32]
                   + {bam_hi, {(32 - drpi_pkg::FracBits){1'b0}}};

  always_comb begin
    q_sat = quo;
    if (vneg && quo > drpi_pkg::ProdW'(33'h1_0000_0000 >> 1))
      q_sat = drpi_pkg::ProdW'(33'h0_8000_0000);
    else if (!vneg && quo > drpi_pkg::ProdW'(32'h7FFF_FFFF))
      q_sat = drpi_pkg::ProdW'(32'h7FFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      substep_count <= drpi_pkg::CountW'(1);
      x_position    <= '0;
      y_position    <= '0;
      heading_angle <= '0;
      out_valid     <= 1'b0;
      remaining     <= '0;
      div_cnt       <= '0;
    end else begin
      if (out_load)
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid)
            substep_count <= cfg_data;
          if (in_valid) begin
            t_reg <= in_data.elapsed_time;
            vneg  <= in_data.linear_speed[31];
            wneg  <= in_data.turn_rate[31];
            vmag  <= in_data.linear_speed[31] ? 33'(-{1'b1, in_data.linear_speed})
                                              : {1'b0, in_data.linear_speed};
            wmag  <= in_data.turn_rate[31] ? 33'(-{1'b1, in_data.turn_rate})
                                           : {1'b0, in_data.turn_rate};
            state <= S_MULV;
          end
        end
        S_MULV: begin
          quo     <= drpi_pkg::ProdW'({24'd0, vmag} * {33'd0, t_reg})
                     + drpi_pkg::ProdW'(divisor >> 1);
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIVV;
        end
        S_DIVV, S_DIVW: begin
          if (!trial[drpi_pkg::DivW]) begin
            rem <= trial[drpi_pkg::ProdW-1:0];
            quo <= {quo[drpi_pkg::ProdW-2:0], 1'b1};
          end else begin
            rem <= {rem[drpi_pkg::ProdW-2:0], quo[drpi_pkg::ProdW-1]};
            quo <= {quo[drpi_pkg::ProdW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'(drpi_pkg::ProdW - 1))
            state <= (state == S_DIVV) ? S_MULW : S_BAM;
        end
        S_MULW: begin
          step_dist <= vneg ? -$signed({1'b0, q_sat[31:0]}) : $signed({1'b0, q_sat[31:0]});
          quo       <= drpi_pkg::ProdW'({24'd0, wmag} * {33'd0, t_reg})
                       + drpi_pkg::ProdW'(divisor >> 1);
          rem       <= '0;
          div_cnt   <= '0;
          state     <= S_DIVW;
        end
        S_BAM: begin
          bam       <= wneg ? -bam_raw : bam_raw;
          remaining <= n_eff;
          state     <= S_ROT;
        end
        S_ROT: state <= S_WAIT;
        S_WAIT: begin
          if (crsp.done) begin
            cos_r <= crsp.cos_val;
            sin_r <= crsp.sin_val;
            state <= S_MULX;
          end
        end
        S_MULX: begin
          mac   <= step_dist * cos_r + 67'sd536870912;
          state <= S_MULY;
        end
        S_MULY: begin
          x_position    <= x_position + mac[61:30];
          mac           <= step_dist * sin_r + 67'sd536870912;
          heading_angle <= heading_angle + bam;
          remaining     <= remaining - 1'b1;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (remaining != '0) begin
            y_position <= y_position + mac[61:30];
            state      <= S_ROT;
          end else if (out_load) begin
            y_position       <= y_position + mac[61:30];
            out_data.pos_x   <= $signed(x_position);
            out_data.pos_y   <= $signed(y_position + mac[61:30]);
            out_data.heading <= heading_angle;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/drpi_checker.sv
// port-level checker for the pose integrator, bound to the top level
module drpi_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input drpi_pkg::out_item_t out_data,
  input logic                cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !in_stall)
    else $error("config ready outside idle");

  a_no_result_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared right after request");

endmodule

bind dead_reckoning_pose_integrator drpi_checker u_drpi_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_ready(cfg_ready)
);
